// File: rtl/core/tsb_pkg.sv
package tsb_pkg;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Widest internal coordinates over the supported geometry range
  localparam int ROW_MAX_W = 6;
  localparam int COL_MAX_W = 7;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SETCUR = 2'd1,
    OP_PUT    = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] row;
    logic [5:0] col;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [4:0] cursor_row;
    logic [5:0] cursor_col;
    logic       scrolled;
  } out_item_t;

  // Classified command handed from the front end to the back end
  typedef struct packed {
    logic [1:0]           operation;
    logic [ROW_MAX_W-1:0] row;
    logic [COL_MAX_W-1:0] col;
    logic [7:0]           char_code;
    logic                 in_range;
    logic                 scroll;
    logic [4:0]           cursor_row;
    logic [5:0]           cursor_col;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_SWEEP,
    BK_BLANK,
    BK_RDWAIT,
    BK_EMIT
  } bk_state_t;

endpackage

// File: rtl/core/tsb_front.sv
module tsb_front #(
  parameter int ROWS = 24,
  parameter int COLS = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsb_pkg::in_item_t in_data,
  input  logic              init_done,
  input  logic              q_full,
  output logic              q_push,
  output tsb_pkg::cmd_t     q_data
);
  import tsb_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int RXW = (RW > 5) ? RW : 5;
  localparam int CXW = (CW > 6) ? CW : 6;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

  logic [RW-1:0]        cur_row_r, cur_row_nxt;
  logic [CW-1:0]        cur_col_r, cur_col_nxt;
  logic [ROW_MAX_W-1:0] row_x;
  logic [COL_MAX_W-1:0] col_x;
  logic                 row_ok, col_ok;
  logic                 scroll;
  logic [RXW-1:0]       row_out_x;
  logic [CXW-1:0]       col_out_x;

  assign in_ready = init_done && !q_full;
  assign q_push   = in_valid && in_ready;

  assign row_x  = {1'b0, in_data.row};
  assign col_x  = {1'b0, in_data.col};
  assign row_ok = {27'd0, in_data.row} < 32'(ROWS);
  assign col_ok = {26'd0, in_data.col} < 32'(COLS);

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    scroll      = 1'b0;
    case (in_data.operation)
      OP_CLEAR: begin
        cur_row_nxt = '0;
        cur_col_nxt = '0;
      end
      OP_SETCUR: begin
        if (row_ok) cur_row_nxt = row_x[RW-1:0];
        if (col_ok) cur_col_nxt = col_x[CW-1:0];
      end
      OP_PUT: begin
        if (cur_col_r == LAST_COL) begin
          cur_col_nxt = '0;
          if (cur_row_r == LAST_ROW) begin
            scroll = 1'b1;
          end else begin
            cur_row_nxt = cur_row_r + 1'b1;
          end
        end else begin
          cur_col_nxt = cur_col_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign row_out_x = RXW'(cur_row_nxt);
  assign col_out_x = CXW'(cur_col_nxt);

  always_comb begin
    q_data.operation  = in_data.operation;
    q_data.char_code  = in_data.char_code;
    q_data.scroll     = scroll;
    q_data.cursor_row = row_out_x[4:0];
    q_data.cursor_col = col_out_x[5:0];
    q_data.in_range   = row_ok && col_ok;
    if (in_data.operation == OP_PUT) begin
      q_data.row = ROW_MAX_W'(cur_row_r);
      q_data.col = COL_MAX_W'(cur_col_r);
    end else begin
      q_data.row = row_x;
      q_data.col = col_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else if (q_push) begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

endmodule

// File: rtl/core/tsb_queue.sv
module tsb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tsb_pkg::cmd_t push_data,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output tsb_pkg::cmd_t pop_data
);
  import tsb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full      = count_r == NW'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// File: rtl/core/tsb_back.sv
module tsb_back #(
  parameter int ROWS = 24,
  parameter int COLS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tsb_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               init_done,
  output logic               out_valid,
  input  logic               out_ready,
  output tsb_pkg::out_item_t out_data
);
  import tsb_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int AW = RW + CW;
  localparam int DEPTH = ROWS << CW;
  localparam logic [RW:0]   ROWS_X = (RW + 1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

  bk_state_t     state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [RW-1:0] srow_r, srow_nxt;
  logic [CW-1:0] scol_r, scol_nxt;
  logic [7:0]    rdata_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic [7:0]    mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  logic          slot_free, out_load;
  logic          sweep_last;
  logic [RW-1:0] q_phys;
  logic [RW-1:0] top_adv;

  // Map a screen row onto its storage row through the rotating top pointer
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
                                             input logic [RW-1:0] top);
    logic [RW:0] s;
    s = {1'b0, lr} + {1'b0, top};
    if (s >= ROWS_X) s = s - ROWS_X;
    return s[RW-1:0];
  endfunction

  assign q_phys     = phys_row(q_data.row[RW-1:0], top_r);
  assign top_adv    = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
  assign sweep_last = (srow_r == LAST_ROW) && (scol_r == LAST_COL);
  assign slot_free  = !out_valid_r || out_ready;
  assign init_done  = state_r != BK_INIT;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_INIT: begin
        if (sweep_last) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid) begin
          case (q_data.operation)
            OP_CLEAR:  state_nxt = BK_SWEEP;
            OP_SETCUR: state_nxt = BK_EMIT;
            OP_PUT:    state_nxt = q_data.scroll ? BK_BLANK : BK_EMIT;
            OP_READ:   state_nxt = q_data.in_range ? BK_RDWAIT : BK_EMIT;
            default:   state_nxt = BK_EMIT;
          endcase
        end
      end
      BK_SWEEP: begin
        if (sweep_last) state_nxt = BK_EMIT;
      end
      BK_BLANK: begin
        if (scol_r == LAST_COL) state_nxt = BK_EMIT;
      end
      BK_RDWAIT: state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (slot_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = {srow_r, scol_r};
    mem_wdata = SPACE_CHAR;
    mem_re    = 1'b0;
    mem_raddr = {q_phys, q_data.col[CW-1:0]};
    cmd_nxt   = cmd_r;
    top_nxt   = top_r;
    srow_nxt  = srow_r;
    scol_nxt  = scol_r;
    out_load  = 1'b0;
    case (state_r)
      BK_INIT, BK_SWEEP: begin
        mem_we  = 1'b1;
        top_nxt = '0;
        if (scol_r == LAST_COL) begin
          scol_nxt = '0;
          srow_nxt = (srow_r == LAST_ROW) ? '0 : srow_r + 1'b1;
        end else begin
          scol_nxt = scol_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          if (q_data.operation == OP_PUT) begin
            mem_we    = 1'b1;
            mem_waddr = {q_phys, q_data.col[CW-1:0]};
            mem_wdata = q_data.char_code;
          end
          if (q_data.operation == OP_READ) mem_re = q_data.in_range;
        end
      end
      BK_BLANK: begin
        // Blank the old top row, which becomes the new bottom row
        mem_we    = 1'b1;
        mem_waddr = {top_r, scol_r};
        if (scol_r == LAST_COL) begin
          scol_nxt = '0;
          top_nxt  = top_adv;
        end else begin
          scol_nxt = scol_r + 1'b1;
        end
      end
      BK_EMIT: begin
        out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (out_load) begin
      out_data_r.read_char  <= (cmd_r.operation == OP_READ && cmd_r.in_range) ?
                               rdata_r : 8'd0;
      out_data_r.cursor_row <= cmd_r.cursor_row;
      out_data_r.cursor_col <= cmd_r.cursor_col;
      out_data_r.scrolled   <= cmd_r.scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      top_r       <= '0;
      srow_r      <= '0;
      scol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      srow_r  <= srow_nxt;
      scol_r  <= scol_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/text_screen_buffer_scroll_top.sv
// Each accepted word is queued, then popped by the back-end sequencer and answered from
// BK_EMIT once the output slot is free; an in-range read adds BK_RDWAIT for the RAM read.
// The sequencer handles one word at a time; the queue keeps accepting words until full.
// Put character that scrolls also blanks one row (BK_BLANK); clear screen rewrites every
// cell (BK_SWEEP), one cell RAM write per cycle.
// Reset: synchronous, active low; a clearing pass over every cell fills the RAM with
// spaces while in_ready stays low.
module text_screen_buffer_scroll_top #(
  parameter int ROWS = 24,
  parameter int COLS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tsb_pkg::out_item_t out_data
);
  import tsb_pkg::*;

  logic init_done;
  logic q_full, q_push, q_not_empty, q_pop;
  cmd_t push_cmd, pop_cmd;

  tsb_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_cmd)
  );

  tsb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_data  (pop_cmd)
  );

  tsb_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (pop_cmd),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
